FILE: design/abpc_pkg.sv
`default_nettype none
package abpc_pkg;

    localparam int MODE_W = 3;
    localparam int DIST_W = 16;
    localparam int TEMP_W = 13;
    localparam int DUR_W = 16;
    localparam int TIME_W = 32;
    localparam int PHASE_W = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [MODE_W-1:0] MODE_TICK = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SENSOR = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MANUAL = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LATCH = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SILENCE = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROX_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_LIMIT = 2'd2;

    localparam logic [DIST_W-1:0] PROX_LIMIT_RESET = 16'd500;
    localparam logic signed [TEMP_W-1:0] TEMP_LIMIT_RESET = 13'sd520;

    localparam logic [PHASE_W-1:0] BEEP_ON_MS = 10'd100;
    localparam logic [PHASE_W-1:0] BEEP_SLOT_MS = 10'd200;
    localparam logic [PHASE_W-1:0] PATTERN_LAST = 10'd799;
    localparam logic [PHASE_W-1:0] PATTERN_MS = 10'd800;
    localparam logic [TIME_W-1:0] PROX_HOLD_MS = 32'd3000;
    localparam logic [TIME_W-1:0] TEMP_HOLD_MS = 32'd2000;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic motion;
        logic [DIST_W-1:0] distance;
        logic signed [TEMP_W-1:0] temperature;
        logic [DUR_W-1:0] duration;
        logic latch_on;
    } t_item;

    typedef struct packed {
        logic buzzer;
        logic status_led;
        logic security_active;
        logic manual_timed;
        logic manual_latched;
    } t_result;

    typedef struct packed {
        logic block_enabled;
        logic [DIST_W-1:0] proximity_limit;
        logic signed [TEMP_W-1:0] temp_limit;
    } t_cfg;

    // The pattern beeps during the first 100 ms of each of the first three 200 ms slots.
    function automatic logic beep_on(input logic [PHASE_W-1:0] phase);
        logic b0;
        logic b1;
        logic b2;
        b0 = phase < BEEP_ON_MS;
        b1 = (phase >= BEEP_SLOT_MS) && (phase < BEEP_SLOT_MS + BEEP_ON_MS);
        b2 = (phase >= 2 * BEEP_SLOT_MS) && (phase < 2 * BEEP_SLOT_MS + BEEP_ON_MS);
        return b0 || b1 || b2;
    endfunction

endpackage
`default_nettype wire

FILE: design/abpc_if.sv
`default_nettype none
interface abpc_in_if import abpc_pkg::*; ();
    logic valid;
    logic ready;
    logic [MODE_W-1:0] mode;
    logic motion;
    logic [DIST_W-1:0] distance;
    logic signed [TEMP_W-1:0] temperature;
    logic [DUR_W-1:0] duration;
    logic latch_on;

    modport source (output valid, mode, motion, distance, temperature, duration, latch_on,
                    input ready);
    modport sink (input valid, mode, motion, distance, temperature, duration, latch_on,
                  output ready);
endinterface

interface abpc_out_if;
    logic valid;
    logic ready;
    logic buzzer;
    logic status_led;
    logic security_active;
    logic manual_timed;
    logic manual_latched;

    modport source (output valid, buzzer, status_led, security_active, manual_timed,
                    manual_latched, input ready);
    modport sink (input valid, buzzer, status_led, security_active, manual_timed,
                  manual_latched, output ready);
endinterface

interface abpc_cfg_if import abpc_pkg::*; ();
    logic valid;
    logic ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: design/abpc_cfg_regs.sv
`default_nettype none
module abpc_cfg_regs import abpc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    abpc_cfg_if.sink  i_cfg,
    output t_cfg      o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_ENABLE:     n_cfg.block_enabled = i_cfg.data[0];
                REG_PROX_LIMIT: n_cfg.proximity_limit = i_cfg.data[DIST_W-1:0];
                REG_TEMP_LIMIT: n_cfg.temp_limit = i_cfg.data[TEMP_W-1:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.block_enabled <= 1'b0;
            r_cfg.proximity_limit <= PROX_LIMIT_RESET;
            r_cfg.temp_limit <= TEMP_LIMIT_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule
`default_nettype wire

FILE: design/abpc_in_stage.sv
`default_nettype none
module abpc_in_stage import abpc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    abpc_in_if.sink   i_item,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_item     o_item
);

    logic  r_valid;
    t_item r_item;
    logic  w_load;

    assign i_item.ready = !r_valid || i_ready;
    assign w_load = i_item.valid && i_item.ready;
    assign o_valid = r_valid;
    assign o_item = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item.mode <= i_item.mode;
            r_item.motion <= i_item.motion;
            r_item.distance <= i_item.distance;
            r_item.temperature <= i_item.temperature;
            r_item.duration <= i_item.duration;
            r_item.latch_on <= i_item.latch_on;
        end
    end

endmodule
`default_nettype wire

FILE: design/abpc_core.sv
`default_nettype none
module abpc_core import abpc_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_item i_item,
    input  wire t_cfg  i_cfg,
    abpc_out_if.source o_result
);

    logic [TIME_W-1:0]  r_now, n_now;
    logic [TIME_W-1:0]  r_security_end, n_security_end;
    logic [TIME_W-1:0]  r_manual_end, n_manual_end;
    logic [TIME_W-1:0]  r_pattern_start, n_pattern_start;
    logic [PHASE_W-1:0] r_now_mod, n_now_mod;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic r_security, n_security;
    logic r_manual, n_manual;
    logic r_latched, n_latched;
    logic r_buzzer, n_buzzer;
    logic r_led, n_led;
    logic r_out_valid;

    logic [TIME_W-1:0] w_now_p1;
    logic w_fire;
    logic w_prox;
    logic w_hot;
    logic w_done;

    assign o_ready = !r_out_valid || o_result.ready;
    assign w_fire = i_valid && o_ready;
    assign w_now_p1 = r_now + 1'b1;
    assign w_prox = (i_item.distance != '0) && (i_item.distance < i_cfg.proximity_limit);
    assign w_hot = i_item.temperature > i_cfg.temp_limit;

    // The phase register always equals (now - pattern start) modulo 800, and the
    // now_mod register equals now modulo 800, both following 32-bit wraparound.
    always_comb begin
        n_now = r_now;
        n_security_end = r_security_end;
        n_manual_end = r_manual_end;
        n_pattern_start = r_pattern_start;
        n_now_mod = r_now_mod;
        n_phase = r_phase;
        n_security = r_security;
        n_manual = r_manual;
        n_latched = r_latched;
        n_buzzer = r_buzzer;
        n_led = r_led;
        w_done = 1'b0;
        unique case (i_item.mode)
            MODE_TICK: begin
                n_now = w_now_p1;
                if (r_now == '1 || r_now_mod == PATTERN_LAST) begin
                    n_now_mod = '0;
                end else begin
                    n_now_mod = r_now_mod + 1'b1;
                end
                if (w_now_p1 == r_pattern_start || r_phase == PATTERN_LAST) begin
                    n_phase = '0;
                end else begin
                    n_phase = r_phase + 1'b1;
                end
            end
            MODE_SENSOR: begin
                if (i_cfg.block_enabled) begin
                    if (r_manual && r_now >= r_manual_end) begin
                        n_manual = 1'b0;
                        if (!r_latched && !r_security) begin
                            n_buzzer = 1'b0;
                            n_led = 1'b0;
                            n_pattern_start = '0;
                            n_phase = r_now_mod;
                            w_done = 1'b1;
                        end
                    end
                    if (!w_done) begin
                        if (!n_manual && !r_latched) begin
                            if (i_item.motion && w_prox) begin
                                n_security = 1'b1;
                                n_security_end = r_now + PROX_HOLD_MS;
                                n_pattern_start = r_now;
                                n_phase = '0;
                            end else if (w_hot) begin
                                n_security = 1'b1;
                                n_security_end = r_now + TEMP_HOLD_MS;
                                n_pattern_start = r_now;
                                n_phase = '0;
                            end else if (r_security && r_now >= r_security_end) begin
                                n_security = 1'b0;
                            end
                        end
                        if (!n_manual && !r_latched && !n_security) begin
                            n_buzzer = 1'b0;
                            n_led = 1'b0;
                            n_pattern_start = '0;
                            n_phase = r_now_mod;
                        end else begin
                            n_buzzer = beep_on(n_phase);
                            n_led = 1'b1;
                        end
                    end
                end
            end
            MODE_MANUAL: begin
                if (i_cfg.block_enabled) begin
                    n_manual = 1'b1;
                    n_manual_end = r_now + {{(TIME_W-DUR_W){1'b0}}, i_item.duration};
                    n_pattern_start = r_now;
                    n_phase = '0;
                    n_led = 1'b1;
                end
            end
            MODE_LATCH: begin
                if (i_cfg.block_enabled) begin
                    if (i_item.latch_on) begin
                        if (!r_latched) begin
                            n_latched = 1'b1;
                            n_pattern_start = r_now;
                            n_phase = '0;
                        end
                        n_led = 1'b1;
                    end else if (r_latched) begin
                        n_latched = 1'b0;
                        n_security = 1'b0;
                        n_buzzer = 1'b0;
                        n_led = 1'b0;
                        n_pattern_start = '0;
                        n_phase = r_now_mod;
                    end else begin
                        n_security = 1'b0;
                        if (!r_manual) begin
                            n_buzzer = 1'b0;
                            n_led = 1'b0;
                            n_pattern_start = '0;
                            n_phase = r_now_mod;
                        end
                    end
                end
            end
            MODE_SILENCE: begin
                n_security = 1'b0;
                if (!r_latched && !r_manual) begin
                    n_buzzer = 1'b0;
                    n_led = 1'b0;
                    n_pattern_start = '0;
                    n_phase = r_now_mod;
                end
            end
            default: begin
                n_now = r_now;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now <= '0;
            r_security_end <= '0;
            r_manual_end <= '0;
            r_pattern_start <= '0;
            r_now_mod <= '0;
            r_phase <= '0;
            r_security <= 1'b0;
            r_manual <= 1'b0;
            r_latched <= 1'b0;
            r_buzzer <= 1'b0;
            r_led <= 1'b0;
        end else if (w_fire) begin
            r_now <= n_now;
            r_security_end <= n_security_end;
            r_manual_end <= n_manual_end;
            r_pattern_start <= n_pattern_start;
            r_now_mod <= n_now_mod;
            r_phase <= n_phase;
            r_security <= n_security;
            r_manual <= n_manual;
            r_latched <= n_latched;
            r_buzzer <= n_buzzer;
            r_led <= n_led;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ready) begin
            r_out_valid <= i_valid;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.buzzer = r_buzzer;
    assign o_result.status_led = r_led;
    assign o_result.security_active = r_security;
    assign o_result.manual_timed = r_manual;
    assign o_result.manual_latched = r_latched;

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase < PATTERN_MS)
        else $error("pattern phase out of range");

    a_now_mod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_now_mod < PATTERN_MS)
        else $error("millisecond residue out of range");

    a_buzzer_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_buzzer |-> r_led)
        else $error("buzzer on with LED off");

    a_tick_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && i_item.mode == MODE_TICK) |=> (r_now == $past(r_now) + 1'b1))
        else $error("tick did not advance the clock");

endmodule
`default_nettype wire

FILE: design/alarm_beep_pattern_controller.sv
// An accepted input passes the input register, then the core's result register.
// Throughput: one item per cycle while o_result is ready; the whole state update
// for an item is combinational between the input register and the result register.
// Reset (synchronous, active low): all timers, flags and outputs clear to zero,
// the block is disabled, and the limits return to 500 (0.1 cm) and 520 (0.1 degC).
`default_nettype none
module alarm_beep_pattern_controller import abpc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    abpc_cfg_if.sink  i_cfg,
    abpc_in_if.sink   i_item,
    abpc_out_if.source o_result
);

    t_cfg  w_cfg;
    t_item w_item;
    logic  w_item_valid;
    logic  w_core_ready;

    abpc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    abpc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .o_valid (w_item_valid),
        .i_ready (w_core_ready),
        .o_item  (w_item)
    );

    abpc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_item_valid),
        .o_ready  (w_core_ready),
        .i_item   (w_item),
        .i_cfg    (w_cfg),
        .o_result (o_result)
    );

endmodule
`default_nettype wire
